// ===== hw/rtl/bss_pkg.sv =====
// ============================================================================
// bss_pkg
// Shared types, codes and defaults of the byte signature scanner.
// ============================================================================
package bss_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_PATTERN_DEFAULT = 25;
    localparam int OFFSET_BITS_DEFAULT = 32;

    // Signature bytes held by the configuration registers
    localparam int SIG_BYTES = 25;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [4:0]  PATTERN_LENGTH_RESET = 5'd1;
    localparam logic [15:0] MATCH_LIMIT_RESET    = 16'd2000;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_WORD0  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_WORD1  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_WORD2  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_WORD3  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_LIMIT    = 3'd5;

    // Result kinds
    localparam logic KIND_MATCH   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Result queue
    localparam int RESULT_DEPTH = 4;
    localparam int RPTR_W       = 2;
    localparam int RCOUNT_W     = 3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] match_offset;
        logic [15:0] match_total;
        logic        is_last;
    } result_t;

    typedef struct packed {
        logic [SIG_BYTES-1:0][7:0] signature;
        logic [4:0]                pattern_length;
        logic [15:0]               match_limit;
    } cfg_t;

    // Results produced by one accepted byte; second is only set with first
    typedef struct packed {
        logic    first_valid;
        logic    second_valid;
        result_t first;
        result_t second;
    } push_t;

endpackage

// ===== hw/rtl/bss_if.sv =====
// ============================================================================
// bss_stream_if
// Valid/ready channel carrying one payload per transaction.
// ============================================================================
interface bss_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/bss_cfg_regs.sv =====
// ============================================================================
// bss_cfg_regs
// Configuration register file: signature bytes, length and match limit.
// ============================================================================
module bss_cfg_regs
    import bss_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    logic [SIG_BYTES-1:0][7:0] signature_reg;
    logic [4:0]                pattern_length_reg;
    logic [15:0]               match_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signature_reg      <= '0;
            pattern_length_reg <= PATTERN_LENGTH_RESET;
            match_limit_reg    <= MATCH_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PATTERN_WORD0:  signature_reg[7:0]   <= cfg_data;
                CFG_PATTERN_WORD1:  signature_reg[15:8]  <= cfg_data;
                CFG_PATTERN_WORD2:  signature_reg[23:16] <= cfg_data;
                CFG_PATTERN_WORD3:  signature_reg[24]    <= cfg_data[7:0];
                CFG_PATTERN_LENGTH: pattern_length_reg   <= cfg_data[4:0];
                CFG_MATCH_LIMIT:    match_limit_reg      <= cfg_data[15:0];
                default:            ; // drop writes to unused indexes
            endcase
        end
    end

    assign cfg.signature      = signature_reg;
    assign cfg.pattern_length = pattern_length_reg;
    assign cfg.match_limit    = match_limit_reg;

endmodule

// ===== hw/rtl/bss_matcher.sv =====
// ============================================================================
// bss_matcher
// Byte window, stream state and combinational signature compare.
// ============================================================================
module bss_matcher
    import bss_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT,
    parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     in_fire,
    input  in_item_t item,
    output push_t    push
);

    localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int SKIP_W = $clog2(MAX_PATTERN + 2);
    localparam int IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [7:0]             window_reg [MAX_PATTERN];
    logic [OFFSET_BITS-1:0] position_reg;
    logic [LEN_W-1:0]       fresh_reg;
    logic [SKIP_W-1:0]      skip_reg;
    logic [15:0]            found_reg;

    logic [7:0]             window_next [MAX_PATTERN];
    logic [OFFSET_BITS-1:0] position_next;
    logic [LEN_W-1:0]       fresh_next;
    logic [SKIP_W-1:0]      skip_next;
    logic [15:0]            found_next;

    logic [7:0]             win_shift [MAX_PATTERN];
    logic [7:0]             sig_ext   [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] byte_ok;
    logic [LEN_W-1:0]       len_eff;
    logic [LEN_W-1:0]       fresh_inc;
    logic                   examine;
    logic                   hit;
    logic [OFFSET_BITS-1:0] start_offset;
    logic [63:0]            start_wide;
    result_t                match_res;
    result_t                summary_res;

    // Signature bytes past the register file read as zero
    for (genvar g = 0; g < MAX_PATTERN; g++)
    begin : g_sig
        if (g < SIG_BYTES)
        begin : g_cfg
            assign sig_ext[g] = cfg.signature[g];
        end
        else
        begin : g_zero
            assign sig_ext[g] = 8'h00;
        end
    end

    // Clamp length: zero acts as one, oversize acts as the window depth
    always_comb
    begin
        if (cfg.pattern_length == 5'd0)
            len_eff = LEN_W'(1);
        else if (32'(cfg.pattern_length) > MAX_PATTERN)
            len_eff = LEN_W'(MAX_PATTERN);
        else
            len_eff = LEN_W'(cfg.pattern_length);
    end

    // Window as it stands after taking this byte, entry 0 newest
    always_comb
    begin
        win_shift[0] = item.data_byte;
        for (int i = 1; i < MAX_PATTERN; i++)
            win_shift[i] = window_reg[i-1];
    end

    // Signature byte i lines up with window entry len-1-i
    always_comb
    begin
        logic [LEN_W-1:0] idx;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            idx = len_eff - LEN_W'(1) - LEN_W'(i);
            if (LEN_W'(i) < len_eff)
                byte_ok[i] = (win_shift[idx[IDX_W-1:0]] == sig_ext[i]);
            else
                byte_ok[i] = 1'b1;
        end
    end

    assign fresh_inc = (fresh_reg < LEN_W'(MAX_PATTERN)) ? fresh_reg + LEN_W'(1) : fresh_reg;
    assign examine   = (skip_reg == '0) && (found_reg < cfg.match_limit);
    assign hit       = examine && (fresh_inc >= len_eff) && (&byte_ok);

    assign start_offset = position_reg - (OFFSET_BITS'(len_eff) - OFFSET_BITS'(1));
    assign start_wide   = 64'(start_offset);

    // Next state
    always_comb
    begin
        window_next   = window_reg;
        position_next = position_reg + OFFSET_BITS'(1);
        fresh_next    = fresh_reg;
        skip_next     = skip_reg;
        found_next    = found_reg;

        if (skip_reg != '0)
        begin
            skip_next = skip_reg - SKIP_W'(1);
        end
        else if (examine)
        begin
            window_next = win_shift;
            fresh_next  = fresh_inc;
            if (hit)
            begin
                found_next = found_reg + 16'd1;
                fresh_next = '0;
                skip_next  = SKIP_W'(len_eff) + SKIP_W'(1);
            end
        end

        if (item.end_of_stream)
        begin
            for (int i = 0; i < MAX_PATTERN; i++)
                window_next[i] = 8'h00;
            position_next = '0;
            fresh_next    = '0;
            skip_next     = '0;
            found_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PATTERN; i++)
                window_reg[i] <= 8'h00;
            position_reg <= '0;
            fresh_reg    <= '0;
            skip_reg     <= '0;
            found_reg    <= '0;
        end
        else if (in_fire)
        begin
            window_reg   <= window_next;
            position_reg <= position_next;
            fresh_reg    <= fresh_next;
            skip_reg     <= skip_next;
            found_reg    <= found_next;
        end
    end

    // Results: a match comes before the summary
    always_comb
    begin
        match_res.result_kind  = KIND_MATCH;
        match_res.match_offset = start_wide[31:0];
        match_res.match_total  = found_reg + 16'd1;
        match_res.is_last      = ~item.end_of_stream;

        summary_res.result_kind  = KIND_SUMMARY;
        summary_res.match_offset = 32'd0;
        summary_res.match_total  = hit ? found_reg + 16'd1 : found_reg;
        summary_res.is_last      = 1'b1;

        push.first_valid  = in_fire && (hit || item.end_of_stream);
        push.second_valid = in_fire && hit && item.end_of_stream;
        push.first        = hit ? match_res : summary_res;
        push.second       = summary_res;
    end

endmodule

// ===== hw/rtl/bss_result_fifo.sv =====
// ============================================================================
// bss_result_fifo
// Four-entry result queue taking up to two results per cycle.
// ============================================================================
module bss_result_fifo
    import bss_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    result_t             entry_reg [RESULT_DEPTH];
    logic [RPTR_W-1:0]   wr_ptr_reg;
    logic [RPTR_W-1:0]   rd_ptr_reg;
    logic [RCOUNT_W-1:0] count_reg;

    logic [RPTR_W-1:0]   wr_ptr_next;
    logic [RPTR_W-1:0]   rd_ptr_next;
    logic [RCOUNT_W-1:0] count_next;
    logic                pop;
    logic [RCOUNT_W-1:0] push_n;

    // Keep room for a match and a summary from the same byte
    assign room      = (count_reg <= RCOUNT_W'(RESULT_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        push_n      = RCOUNT_W'(push.first_valid) + RCOUNT_W'(push.second_valid);
        wr_ptr_next = wr_ptr_reg + RPTR_W'(push_n);
        rd_ptr_next = pop ? rd_ptr_reg + RPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + push_n - RCOUNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.first_valid)
            entry_reg[wr_ptr_reg] <= push.first;
        if (push.second_valid)
            entry_reg[wr_ptr_reg + RPTR_W'(1)] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/byte_signature_scanner.sv =====
// The scanner takes one file byte per cycle while its queue has room, reports
// every start offset of a configured signature of 1 to 25 bytes, skipping
// length+1 bytes after each hit, and closes each stream with a summary
// carrying the match count. The window shift, the parallel compare of all
// signature bytes and the state update finish in the cycle the byte arrives,
// and the results land in a four-entry output queue. Only a final byte that
// also matches yields two results; the queue drains one result per cycle while
// the sink is ready, and the input stalls while fewer than two queue slots
// are free, so sustained rate is one byte per cycle when the output side keeps
// up. No clearing pass follows reset; the scanner is ready once rst_n rises.
// ============================================================================
// byte_signature_scanner
// Top level: configuration registers, matcher and result queue.
// ============================================================================
module byte_signature_scanner
    import bss_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT,
    parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    bss_stream_if.sink             in_stream,
    bss_stream_if.source           out_stream,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t     cfg;
    push_t    push;
    in_item_t item;
    logic     room;
    logic     in_fire;
    result_t  out_data;

    // Register file; writes arrive only while the scanner is idle, a user rule
    bss_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Accept a byte whenever the queue can absorb a match plus a summary
    assign in_stream.ready = room;
    assign in_fire         = in_stream.valid && room;
    assign item            = in_stream.payload;

    // Window, counters and compare; advance state on each accepted transaction
    bss_matcher #(
        .MAX_PATTERN (MAX_PATTERN),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_matcher (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .in_fire (in_fire),
        .item    (item),
        .push    (push)
    );

    // Hold results until the sink takes them, in order
    bss_result_fifo u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_stream.valid),
        .out_ready (out_stream.ready),
        .out_data  (out_data)
    );

    assign out_stream.payload = out_data;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the byte signature scanner. Bytes are pushed
// through the input channel with random gaps while the result channel stalls
// at random. Each accepted byte runs through a cycle-free predictor of the
// scan (sliding window, skip after a hit, match limit, stream summary). Each
// accepted result is compared field by field against the oldest prediction.
// ============================================================================
module tb_top;
    import bss_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 5;
    // Idle cycles after the last result before a register write or the end;
    // covers bytes still in flight that produce no result
    localparam int DRAIN_CYCLES  = 8;
    // Cycles with no transaction on either channel before the run is abandoned
    localparam int STALL_LIMIT   = 4000;
    // Long receiver hold-off used to back the result queue up into the input
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_BYTES   = 120;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    bss_stream_if #(.payload_t(in_item_t)) in_if ();
    bss_stream_if #(.payload_t(result_t))  out_if ();

    byte_signature_scanner u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_if),
        .out_stream (out_if),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Predictor state: register copies and the scan state of one stream
    // ------------------------------------------------------------------------
    logic [7:0]  sig_bytes [SIG_BYTES];
    logic [4:0]  sig_length;
    logic [15:0] hit_limit;

    logic [7:0]  recent_bytes [MAX_PATTERN_DEFAULT];  // entry 0 is the newest
    logic [31:0] next_offset;
    int unsigned fresh_bytes;
    int unsigned bytes_to_skip;
    logic [15:0] hits_in_stream;

    result_t     pending_results [$];
    int unsigned error_count;
    int unsigned bytes_sent;

    // Idling controls of the stimulus and the result sink, and the watchdog count
    bit          source_steady;
    bit          sink_steady;
    int unsigned hold_request;
    int unsigned sink_pause;
    int unsigned quiet_cycles;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Length in use: zero acts as one, anything past the window acts as full
    function automatic int unsigned active_length();
        int unsigned n;
        n = sig_length;
        if (n == 0)
            n = 1;
        if (n > MAX_PATTERN_DEFAULT)
            n = MAX_PATTERN_DEFAULT;
        return n;
    endfunction

    function automatic void clear_scan_state();
        foreach (recent_bytes[i])
            recent_bytes[i] = 8'h00;
        next_offset    = '0;
        fresh_bytes    = 0;
        bytes_to_skip  = 0;
        hits_in_stream = '0;
    endfunction

    function automatic void apply_config(input logic [CFG_INDEX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_PATTERN_WORD0:
                for (int i = 0; i < 8; i++) sig_bytes[i] = value[8*i +: 8];
            CFG_PATTERN_WORD1:
                for (int i = 0; i < 8; i++) sig_bytes[8 + i] = value[8*i +: 8];
            CFG_PATTERN_WORD2:
                for (int i = 0; i < 8; i++) sig_bytes[16 + i] = value[8*i +: 8];
            CFG_PATTERN_WORD3:  sig_bytes[24] = value[7:0];
            CFG_PATTERN_LENGTH: sig_length    = value[4:0];
            CFG_MATCH_LIMIT:    hit_limit     = value[15:0];
            default: ;
        endcase
    endfunction

    // Advance the scan by one byte and queue the results it causes
    function automatic void predict_byte(input logic [7:0] b, input logic eos);
        logic [31:0] here;
        int unsigned len;
        bit          hit;
        result_t     r;
        here        = next_offset;
        next_offset = next_offset + 32'd1;
        if (bytes_to_skip > 0) begin
            bytes_to_skip--;
        end
        else if (hits_in_stream < hit_limit) begin
            len = active_length();
            for (int i = MAX_PATTERN_DEFAULT - 1; i > 0; i--)
                recent_bytes[i] = recent_bytes[i - 1];
            recent_bytes[0] = b;
            if (fresh_bytes < MAX_PATTERN_DEFAULT)
                fresh_bytes++;
            // Compare the newest len bytes at once; the oldest of them meets signature byte 0
            hit = (fresh_bytes >= len);
            for (int i = 0; i < len; i++)
                if (recent_bytes[len - 1 - i] != sig_bytes[i])
                    hit = 1'b0;
            if (hit) begin
                hits_in_stream = hits_in_stream + 16'd1;
                r.result_kind  = KIND_MATCH;
                r.match_offset = here - 32'(len - 1);
                r.match_total  = hits_in_stream;
                r.is_last      = !eos;
                pending_results.push_back(r);
                fresh_bytes    = 0;
                bytes_to_skip  = len + 1;
            end
        end
        // The summary follows any hit on the final byte, even a skipped one
        if (eos) begin
            r.result_kind  = KIND_SUMMARY;
            r.match_offset = '0;
            r.match_total  = hits_in_stream;
            r.is_last      = 1'b1;
            pending_results.push_back(r);
            clear_scan_state();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] %s", $time, msg);
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf(
                "result with none pending: kind %0d offset %0h total %0d last %0d",
                got.result_kind, got.match_offset, got.match_total, got.is_last));
        end
        else begin
            want = pending_results.pop_front();
            if (got.result_kind !== want.result_kind)
                report_mismatch($sformatf("result_kind: got %0d, want %0d",
                    got.result_kind, want.result_kind));
            if (got.match_offset !== want.match_offset)
                report_mismatch($sformatf("match_offset: got %0h, want %0h",
                    got.match_offset, want.match_offset));
            if (got.match_total !== want.match_total)
                report_mismatch($sformatf("match_total: got %0d, want %0d",
                    got.match_total, want.match_total));
            if (got.is_last !== want.is_last)
                report_mismatch($sformatf("is_last: got %0d, want %0d",
                    got.is_last, want.is_last));
        end
    endtask

    // Check the outgoing transaction first, then predict the incoming one, so
    // the order within the edge is fixed. A result can never leave on the
    // same edge that its byte enters.
    always @(posedge clk)
    begin : scoreboard
        if (rst_n) begin
            if (out_if.valid && out_if.ready)
                check_result(out_if.payload);
            if (in_if.valid && in_if.ready)
                predict_byte(in_if.payload.data_byte, in_if.payload.end_of_stream);
        end
    end

    // Abandon the run when neither channel moves for too long
    always @(posedge clk)
    begin : watchdog
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("byte_signature_scanner: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Idling
    // ------------------------------------------------------------------------

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Result sink: random stalls, plus a long hold-off on request. The
    // hold-off is counted here, in cycles, independent of the stimulus.
    always @(negedge clk)
    begin : result_sink
        if (hold_request != 0) begin
            sink_pause   = hold_request;
            hold_request = 0;
        end
        if (sink_pause != 0) begin
            out_if.ready = 1'b0;
            sink_pause--;
        end
        else begin
            out_if.ready = 1'b1;
            if (!sink_steady && $urandom_range(0, 3) == 0)
                sink_pause = pick_gap();
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus primitives; all are entered and left at a falling edge
    // ------------------------------------------------------------------------

    // Offer one byte and hold it until the scanner takes it. Valid stays high
    // into the next call unless that call opens a gap.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        int unsigned gap;
        gap = source_steady ? 0 : pick_gap();
        if (gap != 0) begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_if.payload.data_byte     = b;
        in_if.payload.end_of_stream = eos;
        in_if.valid                 = 1'b1;
        do
            @(posedge clk);
        while (!in_if.ready);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Drop valid, wait for every pending result, then let in-flight bytes settle
    task automatic wait_drained();
        in_if.valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge clk);
        apply_config(idx, value);
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    function automatic logic [63:0] pack_word(input logic [7:0] pat [SIG_BYTES],
                                              input int base);
        logic [63:0] word;
        for (int i = 0; i < 8; i++)
            word[8*i +: 8] = pat[base + i];
        return word;
    endfunction

    // Write all six registers; unused upper data bits carry random junk
    task automatic load_config(input logic [7:0] pat [SIG_BYTES],
                               input logic [4:0] len, input logic [15:0] limit);
        cfg_write(CFG_PATTERN_WORD0, pack_word(pat, 0));
        cfg_write(CFG_PATTERN_WORD1, pack_word(pat, 8));
        cfg_write(CFG_PATTERN_WORD2, pack_word(pat, 16));
        cfg_write(CFG_PATTERN_WORD3, {$urandom, 24'($urandom), pat[24]});
        cfg_write(CFG_PATTERN_LENGTH, {$urandom, 27'($urandom), len});
        cfg_write(CFG_MATCH_LIMIT, {$urandom, 16'($urandom), limit});
    endtask

    // Build one stream mostly from signature copies (some with a bad byte),
    // loose signature bytes and noise, then send it
    task automatic send_stream(input int unsigned target, input bit close_it);
        logic [7:0]  stream_bytes [$];
        int unsigned len;
        int unsigned pick;
        int unsigned bad_pos;
        logic [7:0]  flip;
        len = active_length();
        while (stream_bytes.size() < target) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                bad_pos = (pick == 4) ? $urandom_range(0, len - 1) : len;
                flip    = 8'($urandom_range(1, 255));
                for (int i = 0; i < len; i++)
                    stream_bytes.push_back(sig_bytes[i] ^ ((i == bad_pos) ? flip : 8'h00));
            end
            else if (pick < 8) begin
                stream_bytes.push_back(sig_bytes[$urandom_range(0, len - 1)]);
            end
            else begin
                stream_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
        foreach (stream_bytes[i])
            send_byte(stream_bytes[i], close_it && (i == stream_bytes.size() - 1));
    endtask

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // Reset values: one-byte signature of zero. The hit skips the next two
    // bytes, and the skipped final byte still closes the stream.
    task automatic test_reset_defaults();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        wait_drained();
    endtask

    // Length zero acts as one; a hit on the final byte comes ahead of the summary
    task automatic test_final_byte_hit();
        logic [7:0] pat [SIG_BYTES];
        foreach (pat[i])
            pat[i] = 8'hFF;
        load_config(pat, 5'd0, 16'd2000);
        send_byte(8'hFF, 1'b1);
        wait_drained();
    endtask

    // Limit of zero: nothing is reported, the summary counts zero
    task automatic test_limit_zero();
        logic [7:0] pat [SIG_BYTES];
        foreach (pat[i])
            pat[i] = 8'hFF;
        load_config(pat, 5'd1, 16'd0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        wait_drained();
    endtask

    // Limit reached: after the one allowed hit, matching bytes are ignored
    task automatic test_limit_reached();
        logic [7:0] pat [SIG_BYTES];
        foreach (pat[i])
            pat[i] = 8'hFF;
        load_config(pat, 5'd1, 16'd1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        wait_drained();
    endtask

    // Length above the window acts as full length: all 25 bytes must match
    task automatic test_length_overrange();
        logic [7:0] pat [SIG_BYTES];
        foreach (pat[i])
            pat[i] = 8'($urandom_range(0, 255));
        load_config(pat, 5'd31, 16'd2000);
        foreach (pat[i])
            send_byte(pat[i], i == SIG_BYTES - 1);
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Random streams over a series of register settings
    // ------------------------------------------------------------------------
    task automatic test_random_streams();
        logic [7:0]  pat [SIG_BYTES];
        logic [4:0]  len;
        logic [15:0] limit;
        int unsigned phase_end;
        int unsigned pick;
        int unsigned span;
        bit          two_symbol;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            // Two-symbol signatures overlap themselves and stress the window
            two_symbol = ($urandom_range(0, 3) == 0);
            foreach (pat[i]) begin
                if (phase == 0)
                    pat[i] = 8'hFF;
                else if (phase == 1)
                    pat[i] = 8'h00;
                else if (two_symbol)
                    pat[i] = $urandom_range(0, 1) ? 8'hA5 : 8'h5A;
                else
                    pat[i] = 8'($urandom_range(0, 255));
            end
            pick = $urandom_range(0, 19);
            if (phase == 0)
                len = 5'd25;
            else if (phase == 1)
                len = 5'd1;
            else if (pick == 0)
                len = 5'd0;
            else if (pick == 1)
                len = 5'($urandom_range(26, 31));
            else if (pick < 5)
                len = 5'($urandom_range(7, 25));
            else
                len = 5'($urandom_range(1, 6));
            pick = $urandom_range(0, 15);
            if (phase == 0)
                limit = 16'hFFFF;
            else if (phase == 1)
                limit = 16'd1;
            else if (pick == 0)
                limit = 16'd0;
            else if (pick < 3)
                limit = 16'($urandom_range(1, 3));
            else if (pick == 3)
                limit = 16'hFFFF;
            else
                limit = 16'($urandom_range(4, 65535));

            // Registers change only with the scanner idle
            wait_drained();
            load_config(pat, len, limit);

            // Some phases run without idling on one side or both
            source_steady = ($urandom_range(0, 3) == 0);
            sink_steady   = ($urandom_range(0, 3) == 0);
            phase_end     = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end) begin
                span = ($urandom_range(0, 9) == 0) ? 1
                     : $urandom_range(1, 2 * active_length() + 12);
                // Now and then leave a stream open into the next one or across the next setting
                send_stream(span, $urandom_range(0, 6) != 0);
            end
        end
        source_steady = 1'b0;
        sink_steady   = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Back-pressure: the receiver holds off while bytes keep coming, so the
    // result queue fills and the input stalls; then the sender pauses until
    // every result is out before carrying on.
    // ------------------------------------------------------------------------
    task automatic test_output_stall();
        logic [7:0] pat [SIG_BYTES];
        foreach (pat[i])
            pat[i] = 8'h3C;
        wait_drained();
        load_config(pat, 5'd1, 16'hFFFF);
        @(posedge clk);
        hold_request = HOLD_CYCLES;
        @(negedge clk);
        source_steady = 1'b1;
        for (int i = 0; i < 60; i++)
            send_byte(($urandom_range(0, 4) != 0) ? 8'h3C : 8'($urandom_range(0, 255)),
                      i == 59);
        source_steady = 1'b0;
        wait_drained();
        for (int i = 0; i < 20; i++)
            send_byte(($urandom_range(0, 1) != 0) ? 8'h3C : 8'($urandom_range(0, 255)),
                      i == 19);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_sequence
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_if.valid   = 1'b0;
        in_if.payload = '0;
        out_if.ready  = 1'b0;
        source_steady = 1'b0;
        sink_steady   = 1'b0;
        hold_request  = 0;
        sink_pause    = 0;
        quiet_cycles  = 0;
        error_count   = 0;
        bytes_sent    = 0;

        // Predictor starts from the register reset values
        foreach (sig_bytes[i])
            sig_bytes[i] = 8'h00;
        sig_length = PATTERN_LENGTH_RESET;
        hit_limit  = MATCH_LIMIT_RESET;
        clear_scan_state();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_final_byte_hit();
        test_limit_zero();
        test_limit_reached();
        test_length_overrange();
        test_random_streams();
        test_output_stall();

        wait_drained();
        if (error_count == 0)
            $display("byte_signature_scanner: match");
        else
            $display("byte_signature_scanner: mismatch");
        $finish;
    end

endmodule
